// File: hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and codes for the timeout table scheduler
// Command and result codes, default sizes and the queued command record.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MAX_FIRE  = 16;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] CMD_SCHED  = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_OWNER  = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [2:0] KIND_SCHED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_OWNER     = 3'd4;
  localparam logic [2:0] KIND_FIRED     = 3'd5;
  localparam logic [2:0] KIND_NONE      = 3'd6;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] delay;
    logic [3:0]  handle;
    logic [7:0]  owner;
    logic        handle_ok;
  } op_t;

endpackage

// File: hdl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front: command intake
// Takes commands, checks the handle range and queues them for the back end.
// ----------------------------------------------------------------------------
module tts_front #(
  parameter int DEPTH = tts_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       cmd,
  input  logic [15:0]      delay,
  input  logic [3:0]       handle,
  input  logic [7:0]       owner,
  output logic             busy,
  input  logic             pop,
  output logic             head_valid,
  output tts_pkg::op_t     head
);

  localparam int QAW = (tts_pkg::QDEPTH > 1) ? $clog2(tts_pkg::QDEPTH) : 1;
  localparam int QCW = $clog2(tts_pkg::QDEPTH + 1);

  tts_pkg::op_t   queue [tts_pkg::QDEPTH];
  tts_pkg::op_t   op_in;
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;

  assign busy       = (count == QCW'(tts_pkg::QDEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  always_comb begin
    op_in.cmd       = cmd;
    op_in.delay     = delay;
    op_in.handle    = handle;
    op_in.owner     = owner;
    op_in.handle_ok = ({28'd0, handle} < 32'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(tts_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(tts_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back: timer table engine
// Holds the slot table and clock, runs the slot scans and drives results.
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int DEPTH = tts_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  tts_pkg::op_t head,
  output logic         pop,
  output logic         done,
  output logic [2:0]   kind,
  output logic [3:0]   slot,
  output logic [7:0]   fired_owner,
  output logic [4:0]   removed_count,
  output logic         last
);

  localparam int IW = $clog2(DEPTH);
  localparam int AW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCHED = 3'd1;
  localparam logic [2:0] S_OWNER = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [31:0]      exp_mem [DEPTH];
  logic [7:0]       own_mem [DEPTH];
  logic [31:0]      rd_exp;
  logic [7:0]       rd_own;

  logic [2:0]       state;
  tts_pkg::op_t     cur;
  logic [31:0]      now_s;
  logic [DEPTH-1:0] valid;
  logic [AW-1:0]    scan_addr;
  logic             rd_pend;
  logic [IW-1:0]    rd_idx;
  logic             best_found;
  logic [IW-1:0]    best_idx;
  logic [31:0]      best_exp;
  logic [7:0]       best_own;
  logic             pend_valid;
  logic [IW-1:0]    pend_slot;
  logic [7:0]       pend_own;
  logic [4:0]       fire_cnt;
  logic [4:0]       own_cnt;

  logic [IW-1:0]    scan_idx;
  logic             scan_end;
  logic             scan_done;
  logic [32:0]      sched_sum;
  logic [31:0]      sched_exp;
  logic [31:0]      now_inc;
  logic [IW-1:0]    head_idx;
  logic             mem_we;
  logic             hit_owner;
  logic             hit_exp;

  assign scan_idx  = scan_addr[IW-1:0];
  assign scan_end  = (scan_addr == AW'(DEPTH));
  assign scan_done = scan_end && !rd_pend;
  assign sched_sum = {1'b0, now_s} + {17'd0, cur.delay};
  assign sched_exp = sched_sum[32] ? tts_pkg::TIME_MAX : sched_sum[31:0];
  assign now_inc   = (now_s == tts_pkg::TIME_MAX) ? now_s : now_s + 32'd1;
  assign head_idx  = IW'({{IW{1'b0}}, head.handle});
  assign pop       = (state == S_IDLE) && head_valid;
  assign mem_we    = (state == S_SCHED) && !scan_end && !valid[scan_idx];
  assign hit_owner = rd_pend && valid[rd_idx] && (rd_own == cur.owner);
  // earliest due entry so far, strict compare keeps the lowest slot on ties
  assign hit_exp   = rd_pend && valid[rd_idx] && (rd_exp <= now_s) &&
                     (!best_found || (rd_exp < best_exp));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      exp_mem[scan_idx] <= sched_exp;
      own_mem[scan_idx] <= cur.owner;
    end
    rd_exp <= exp_mem[scan_idx];
    rd_own <= own_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      now_s      <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      done <= 1'b0;

      // read pipeline for the table scans
      if ((state == S_OWNER || state == S_TICK) && !scan_end) begin
        scan_addr <= scan_addr + 1'b1;
        rd_idx    <= scan_idx;
        rd_pend   <= 1'b1;
      end else begin
        rd_pend <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur        <= head;
            scan_addr  <= '0;
            best_found <= 1'b0;
            fire_cnt   <= '0;
            own_cnt    <= '0;
            pend_valid <= 1'b0;
            case (head.cmd)
              tts_pkg::CMD_SCHED: begin
                state <= S_SCHED;
              end
              tts_pkg::CMD_CANCEL: begin
                done          <= 1'b1;
                slot          <= head.handle;
                fired_owner   <= '0;
                removed_count <= '0;
                last          <= 1'b1;
                if (head.handle_ok && valid[head_idx]) begin
                  valid[head_idx] <= 1'b0;
                  kind            <= tts_pkg::KIND_CANCELLED;
                end else begin
                  kind <= tts_pkg::KIND_NOT_FOUND;
                end
              end
              tts_pkg::CMD_OWNER: begin
                state <= S_OWNER;
              end
              tts_pkg::CMD_TICK: begin
                now_s <= now_inc;
                state <= S_TICK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SCHED: begin
          if (scan_end) begin
            done          <= 1'b1;
            kind          <= tts_pkg::KIND_FULL;
            slot          <= '0;
            fired_owner   <= '0;
            removed_count <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else if (!valid[scan_idx]) begin
            valid[scan_idx] <= 1'b1;
            done            <= 1'b1;
            kind            <= tts_pkg::KIND_SCHED;
            slot            <= 4'({4'd0, scan_idx});
            fired_owner     <= '0;
            removed_count   <= '0;
            last            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end

        S_OWNER: begin
          if (hit_owner) begin
            valid[rd_idx] <= 1'b0;
            own_cnt       <= own_cnt + 1'b1;
          end
          if (scan_done) begin
            done          <= 1'b1;
            kind          <= tts_pkg::KIND_OWNER;
            slot          <= '0;
            fired_owner   <= '0;
            removed_count <= own_cnt;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        S_TICK: begin
          if (hit_exp) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_exp   <= rd_exp;
            best_own   <= rd_own;
          end
          if (scan_done) begin
            if (best_found) begin
              // the held entry goes out once we know another one follows
              valid[best_idx] <= 1'b0;
              if (pend_valid) begin
                done          <= 1'b1;
                kind          <= tts_pkg::KIND_FIRED;
                slot          <= 4'({4'd0, pend_slot});
                fired_owner   <= pend_own;
                removed_count <= '0;
                last          <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= best_idx;
              pend_own   <= best_own;
              fire_cnt   <= fire_cnt + 1'b1;
              if (fire_cnt == 5'(tts_pkg::MAX_FIRE - 1)) begin
                state <= S_FLUSH;
              end else begin
                scan_addr  <= '0;
                best_found <= 1'b0;
              end
            end else begin
              done          <= 1'b1;
              removed_count <= '0;
              last          <= 1'b1;
              if (pend_valid) begin
                kind        <= tts_pkg::KIND_FIRED;
                slot        <= 4'({4'd0, pend_slot});
                fired_owner <= pend_own;
              end else begin
                kind        <= tts_pkg::KIND_NONE;
                slot        <= '0;
                fired_owner <= '0;
              end
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end

        S_FLUSH: begin
          done          <= 1'b1;
          kind          <= tts_pkg::KIND_FIRED;
          slot          <= 4'({4'd0, pend_slot});
          fired_owner   <= pend_own;
          removed_count <= '0;
          last          <= 1'b1;
          pend_valid    <= 1'b0;
          state         <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/timeout_table_scheduler.sv
// ----------------------------------------------------------------------------
// timeout_table_scheduler: table of pending timeouts
//
//   channel   handshake        payload
//   command   start / busy     cmd, delay, handle, owner
//   result    done (strobe)    kind, slot, fired_owner, removed_count, last
//
// commands pass a two-entry queue, then the engine works one command at a time
// cancel by handle: answered straight from the idle state; schedule: a scan for the lowest free slot
// cancel by owner: one slot per cycle through the table memory
// tick: one table scan per fired entry, at most 16 per tick, plus a last scan when fewer fire
// busy is high while the queue is full; results leave as single-cycle strobes
// synchronous reset empties the table and zeroes the clock, no clearing pass
// ----------------------------------------------------------------------------
module timeout_table_scheduler #(
  parameter int DEPTH = tts_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [15:0] delay,
  input  logic [3:0]  handle,
  input  logic [7:0]  owner,
  output logic        done,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic [7:0]  fired_owner,
  output logic [4:0]  removed_count,
  output logic        last
);

  tts_pkg::op_t head;
  logic         head_valid;
  logic         pop;

  tts_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .delay      (delay),
    .handle     (handle),
    .owner      (owner),
    .busy       (busy),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tts_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .kind          (kind),
    .slot          (slot),
    .fired_owner   (fired_owner),
    .removed_count (removed_count),
    .last          (last)
  );

`ifndef SYNTHESIS
  // every command other than a tick answers with exactly one result
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    done && (kind == tts_pkg::KIND_SCHED || kind == tts_pkg::KIND_FULL ||
             kind == tts_pkg::KIND_CANCELLED || kind == tts_pkg::KIND_NOT_FOUND ||
             kind == tts_pkg::KIND_OWNER) |-> last)
    else $error("single-result command without last");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    done && kind == tts_pkg::KIND_NONE |-> last && slot == 4'd0 && fired_owner == 8'd0)
    else $error("none-expired result malformed");

  a_count_owner_only: assert property (@(posedge clk) disable iff (rst)
    done && kind != tts_pkg::KIND_OWNER |-> removed_count == 5'd0)
    else $error("removed count outside owner cancel");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    done && kind == tts_pkg::KIND_FULL |-> slot == 4'd0 && fired_owner == 8'd0)
    else $error("full result carries a slot");
`endif

endmodule

// File: tb/timeout_table_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeout_table_scheduler_test: self-checking bench for the timeout table
// Drives schedule, cancel, owner-cancel and tick commands through start/busy.
// A shadow copy of the timer table predicts every result, including firing
// order and ties. Each done strobe is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module timeout_table_scheduler_test;

  localparam int SLOTS        = tts_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 240;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 400;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] fowner;
    logic [4:0] count;
    logic       last;
  } result_t;

  // shadow timer table, one queue of predicted results for all accepted commands
  class timer_table_model;
    bit          armed[SLOTS];
    logic [31:0] expiry[SLOTS];
    logic [7:0]  owner_of[SLOTS];
    logic [31:0] seconds;
    result_t     awaited_results[$];
    int          errors;

    function new();
      seconds = '0;
      errors  = 0;
      foreach (armed[i]) armed[i] = 1'b0;
    endfunction

    function void note_command(logic [1:0] c, logic [15:0] d, logic [3:0] h,
                               logic [7:0] o);
      result_t     r;
      logic [32:0] sum;
      bit          found;
      bit          searching;
      int          best;
      int          n;
      int          count;
      r = '0;
      case (c)
        tts_pkg::CMD_SCHED: begin
          found = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !armed[i]) begin
              found       = 1'b1;
              sum         = {1'b0, seconds} + {17'b0, d};
              armed[i]    = 1'b1;
              expiry[i]   = sum[32] ? tts_pkg::TIME_MAX : sum[31:0];
              owner_of[i] = o;
              r.kind      = tts_pkg::KIND_SCHED;
              r.slot      = 4'(i);
            end
          end
          if (!found) r.kind = tts_pkg::KIND_FULL;
          r.last = 1'b1;
          awaited_results.push_back(r);
        end
        tts_pkg::CMD_CANCEL: begin
          if (h < SLOTS && armed[h]) begin
            armed[h] = 1'b0;
            r.kind   = tts_pkg::KIND_CANCELLED;
          end else begin
            r.kind = tts_pkg::KIND_NOT_FOUND;
          end
          r.slot = h;
          r.last = 1'b1;
          awaited_results.push_back(r);
        end
        tts_pkg::CMD_OWNER: begin
          count = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && owner_of[i] == o) begin
              armed[i] = 1'b0;
              count++;
            end
          end
          r.kind  = tts_pkg::KIND_OWNER;
          r.count = 5'(count);
          r.last  = 1'b1;
          awaited_results.push_back(r);
        end
        default: begin
          if (seconds != tts_pkg::TIME_MAX) seconds++;
          n = 0;
          searching = 1'b1;
          // earliest expiry first, lowest slot wins a tie
          while (searching && n < tts_pkg::MAX_FIRE) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (armed[i] && expiry[i] <= seconds &&
                  (best < 0 || expiry[i] < expiry[best]))
                best = i;
            end
            if (best < 0) begin
              searching = 1'b0;
            end else begin
              armed[best] = 1'b0;
              r = '0;
              r.kind   = tts_pkg::KIND_FIRED;
              r.slot   = 4'(best);
              r.fowner = owner_of[best];
              awaited_results.push_back(r);
              n++;
            end
          end
          if (n == 0) begin
            r = '0;
            r.kind = tts_pkg::KIND_NONE;
            r.last = 1'b1;
            awaited_results.push_back(r);
          end else begin
            awaited_results[awaited_results.size() - 1].last = 1'b1;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d", got.kind, got.slot);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("slot", want.slot, got.slot);
      compare_field("fired_owner", want.fowner, got.fowner);
      compare_field("removed_count", want.count, got.count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = tts_pkg::CMD_SCHED;
  logic [15:0] delay = '0;
  logic [3:0]  handle = '0;
  logic [7:0]  owner = '0;
  logic        busy;
  logic        done;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [7:0]  fired_owner;
  logic [4:0]  removed_count;
  logic        last;

  timer_table_model table_model;
  bit               gaps_on = 1'b1;
  int               cycles = 0;

  timeout_table_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .delay(delay),
    .handle(handle),
    .owner(owner),
    .done(done),
    .kind(kind),
    .slot(slot),
    .fired_owner(fired_owner),
    .removed_count(removed_count),
    .last(last)
  );

  always #10 clk = ~clk;

  // command acceptance and result checking, both on pre-edge values
  always @(posedge clk) begin
    if (!rst && start && !busy) table_model.note_command(cmd, delay, handle, owner);
    if (!rst && done) table_model.check_result({kind, slot, fired_owner, removed_count, last});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** timeout_table_scheduler: FAILED **");
      $finish;
    end
  end

  // called right after a rising edge; returns at the edge that takes the item
  task send_item(logic [1:0] c, logic [15:0] d, logic [3:0] h, logic [7:0] o);
    int gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    cmd    <= c;
    delay  <= d;
    handle <= h;
    owner  <= o;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk); while (table_model.awaited_results.size() > 0);
  endtask

  initial begin
    int          pick;
    logic [1:0]  c;
    logic [15:0] d;
    logic [3:0]  h;
    logic [7:0]  o;
    table_model = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table: nothing expires, nothing to cancel
    send_item(tts_pkg::CMD_TICK, 16'd0, 4'd0, 8'd0);
    send_item(tts_pkg::CMD_CANCEL, 16'd0, 4'd15, 8'd0);
    send_item(tts_pkg::CMD_OWNER, 16'd0, 4'd0, 8'd200);
    // fill every slot, with tied expiries and one far-off entry
    for (int i = 0; i < SLOTS; i++)
      send_item(tts_pkg::CMD_SCHED, (i == 5) ? 16'hFFFF : 16'(i % 3), 4'd0, 8'hFF);
    send_item(tts_pkg::CMD_SCHED, 16'd0, 4'd0, 8'h00);
    send_item(tts_pkg::CMD_TICK, 16'd0, 4'd0, 8'd0);
    send_item(tts_pkg::CMD_CANCEL, 16'd0, 4'd5, 8'd0);
    send_item(tts_pkg::CMD_CANCEL, 16'd0, 4'd5, 8'd0);
    send_item(tts_pkg::CMD_TICK, 16'd0, 4'd0, 8'd0);
    drain();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 32 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (k == RANDOM_ITEMS / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 45) c = tts_pkg::CMD_SCHED;
      else if (pick < 75) c = tts_pkg::CMD_TICK;
      else if (pick < 90) c = tts_pkg::CMD_CANCEL;
      else c = tts_pkg::CMD_OWNER;
      // short delays so entries actually fire, some long ones to hold slots
      d = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 12));
      h = 4'($urandom_range(0, 15));
      o = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 3));
      send_item(c, d, h, o);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (table_model.errors == 0 && table_model.awaited_results.size() == 0)
      $display("** timeout_table_scheduler: PASSED **");
    else
      $display("** timeout_table_scheduler: FAILED **");
    $finish;
  end

endmodule
